### rtl/ktet_pkg.sv
// Package: sizes, command codes and shared types of the keyed tile entry table.
package ktet_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int GRP = 8;
  localparam int NGRP = (MAX_ENTRIES + GRP - 1) / GRP;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_ANY    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [15:0] key;
    logic        flag;
    logic [63:0] epoch;
  } entry_t;

  typedef struct packed {
    logic        hit;
    logic        flag;
    logic [63:0] epoch;
  } match_t;

  typedef struct packed {
    logic             cmp_en;
    logic             wr_en;
    logic             shift_en;
    logic [CNT_W-1:0] count;
    entry_t           req;
  } cell_ctrl_t;

endpackage

### rtl/ktet_if.sv
// Interfaces: request and response channels of the keyed tile entry table.
interface ktet_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] tile_id;
  logic        sel_in;
  logic [63:0] epoch_in;
  logic        last;

  modport source (output valid, cmd, tile_id, sel_in, epoch_in, last, input ready);
  modport sink (input valid, cmd, tile_id, sel_in, epoch_in, last, output ready);
endinterface

interface ktet_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        sel_out;
  logic [63:0] epoch_out;

  modport source (output valid, ok, sel_out, epoch_out, input ready);
  modport sink (input valid, ok, sel_out, epoch_out, output ready);
endinterface

### rtl/keyed_tile_entry_table.sv
// Top level: keyed tile entry table built as a chain of slot cells.
// One item is in flight. Clear ends at accept; the others take the steps:
// accept, per-cell compare, registered group OR, then update and result.
// Results wait for rsp.ready; any-selected answers only on its last item.
// Synchronous active-high reset empties the table and the any-selected run.
module keyed_tile_entry_table (
  input  logic      clk,
  input  logic      rst,
  ktet_in_if.sink   req,
  ktet_out_if.source rsp
);
  import ktet_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_GRP  = 4'b0100,
    ST_ACT  = 4'b1000
  } state_t;

  state_t           state, state_next;
  cmd_t             cmd;
  entry_t           req_ent;
  logic             req_last;
  logic [CNT_W-1:0] count;
  logic             any_acc;
  logic             out_valid;
  logic             out_ok;
  logic             out_sel;
  logic [63:0]      out_epoch;

  cell_ctrl_t ctrl;
  entry_t     ents [MAX_ENTRIES];
  match_t     cell_hits [MAX_ENTRIES];
  match_t     sum;

  logic accept, produces, act_go, full, any_next;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign produces  = (cmd != CMD_ANY) || req_last;
  assign act_go    = (state == ST_ACT) && (!produces || !out_valid || rsp.ready);
  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign any_next  = any_acc || (sum.hit && sum.flag);

  always_comb begin
    ctrl          = '0;
    ctrl.cmp_en   = (state == ST_CMP);
    ctrl.count    = count;
    ctrl.req      = req_ent;
    ctrl.wr_en    = act_go && (cmd == CMD_ADD) && !full && sum.hit;
    ctrl.shift_en = act_go && (cmd == CMD_ADD) && !full && !sum.hit;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ktet_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (IDX_W'(i)),
      .ctrl  (ctrl),
      .prev  ((i == 0) ? req_ent : ents[(i == 0) ? 0 : i - 1]),
      .ent   (ents[i]),
      .match (cell_hits[i])
    );
  end

  ktet_reduce u_reduce (
    .clk   (clk),
    .match (cell_hits),
    .sum   (sum)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && cmd_t'(req.cmd) != CMD_CLEAR) state_next = ST_CMP;
      ST_CMP:  state_next = ST_GRP;
      ST_GRP:  state_next = ST_ACT;
      ST_ACT:  if (act_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd           <= cmd_t'(req.cmd);
      req_ent.key   <= req.tile_id;
      req_ent.flag  <= req.sel_in;
      req_ent.epoch <= req.epoch_in;
      req_last      <= req.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      any_acc   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && cmd_t'(req.cmd) == CMD_CLEAR) begin
        count   <= '0;
        any_acc <= 1'b0;
      end
      if (ctrl.shift_en) begin
        count <= count + 1'b1;
      end
      if (act_go && cmd == CMD_ANY) begin
        any_acc <= req_last ? 1'b0 : any_next;
      end
      if (act_go && produces) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act_go && produces) begin
      case (cmd)
        CMD_ADD: begin
          out_ok    <= !full;
          out_sel   <= 1'b0;
          out_epoch <= '0;
        end
        CMD_LOOKUP: begin
          out_ok    <= sum.hit;
          out_sel   <= sum.flag;
          out_epoch <= sum.epoch;
        end
        CMD_ANY: begin
          out_ok    <= any_next;
          out_sel   <= 1'b0;
          out_epoch <= '0;
        end
        default: begin
          out_ok    <= 1'b0;
          out_sel   <= 1'b0;
          out_epoch <= '0;
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.ok        = out_ok;
  assign rsp.sel_out   = out_sel;
  assign rsp.epoch_out = out_epoch;

endmodule

### rtl/ktet_cell.sv
// Cell: one table slot with key compare; shifts from its neighbor on append.
module ktet_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ktet_pkg::IDX_W-1:0] idx,
  input  ktet_pkg::cell_ctrl_t     ctrl,
  input  ktet_pkg::entry_t         prev,
  output ktet_pkg::entry_t         ent,
  output ktet_pkg::match_t         match
);
  import ktet_pkg::*;

  logic hit;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      ent <= prev;
    end else if (ctrl.wr_en && hit) begin
      ent.flag  <= ctrl.req.flag;
      ent.epoch <= ctrl.req.epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit <= (CNT_W'(idx) < ctrl.count) && (ent.key == ctrl.req.key);
    end
  end

  always_comb begin
    match = '0;
    if (hit) begin
      match.hit   = 1'b1;
      match.flag  = ent.flag;
      match.epoch = ent.epoch;
    end
  end

endmodule

### rtl/ktet_reduce.sv
// Reduce: registered group OR of cell matches, then OR over the groups.
module ktet_reduce (
  input  logic             clk,
  input  ktet_pkg::match_t match [ktet_pkg::MAX_ENTRIES],
  output ktet_pkg::match_t sum
);
  import ktet_pkg::*;

  match_t grp [NGRP];

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      match_t acc;
      acc = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < MAX_ENTRIES) begin
          acc = match_t'(acc | match[g * GRP + j]);
        end
      end
      grp[g] <= acc;
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum = match_t'(sum | grp[g]);
    end
  end

endmodule

### rtl/ktet_check.sv
// Checker: port-level properties of the keyed tile entry table, bound to the top level.
module ktet_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic        out_sel,
  input logic [63:0] out_epoch
);
  import ktet_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("response beat dropped while stalled");

  a_busy_after_op: assert property (@(posedge clk) disable iff (rst)
    in_beat && in_cmd != CMD_CLEAR |=> !in_ready)
    else $error("request taken while an operation is in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_beat && in_cmd != CMD_CLEAR |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("response appeared before the table search finished");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    in_beat && in_cmd == CMD_CLEAR |=> in_ready)
    else $error("clear did not return to idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> !out_sel && out_epoch == 64'd0)
    else $error("failed response carries nonzero data");

endmodule

bind keyed_tile_entry_table ktet_check u_ktet_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .in_cmd    (req.cmd),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_ok    (rsp.ok),
  .out_sel   (rsp.sel_out),
  .out_epoch (rsp.epoch_out)
);
